### sv/first_fit_arena_allocator_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arena allocator assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define FFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arena allocator assertion failed");

`endif

### sv/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  // Arena geometry.
  localparam int ARENA_BYTES  = 65536;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_SEGMENTS = 256;
  localparam int SPLIT_SLACK  = 64;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int OFF_W  = 16;
  localparam int BODY_W = 17;

  localparam logic [BODY_W-1:0] BODY_INIT = BODY_W'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_SEGMENTS);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  // One segment table entry, with its used mark.
  typedef struct packed {
    logic [OFF_W-1:0]  hdr;
    logic [BODY_W-1:0] body;
    logic [OFF_W-1:0]  pay;
    logic              used;
  } seg_rec_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_START,
    CMD_RD_IDX,
    CMD_ALIGN,
    CMD_NEXT,
    CMD_TAKE,
    CMD_TAKE_SPLIT,
    CMD_SH_UP_RD,
    CMD_SH_UP_WR,
    CMD_INS_WR,
    CMD_FREE_HIT,
    CMD_CAP,
    CMD_MERGE_WR,
    CMD_SH_DN_RD,
    CMD_SH_DN_WR,
    CMD_DEC,
    CMD_OK,
    CMD_OOM,
    CMD_UNKNOWN,
    CMD_PUBLISH
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic addr_zero;
    logic idx_end;
    logic fit;
    logic split;
    logic match;
    logic last;
    logic pair_free;
    logic up_done;
    logic dn_done;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_A_RD,
    S_A_ALIGN,
    S_A_FIT,
    S_UP_CHK,
    S_UP_WR,
    S_F_RD,
    S_F_CMP,
    S_M_CHK,
    S_M_CAP,
    S_M_WR,
    S_DN_CHK,
    S_DN_WR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### sv/ffa_req_if.sv
`default_nettype none
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] req_size;
  logic [3:0]  align_log2;
  logic [15:0] address;

  modport source (output valid, operation, req_size, align_log2, address, input ready);
  modport sink   (input valid, operation, req_size, align_log2, address, output ready);
endinterface
`default_nettype wire

### sv/ffa_rsp_if.sv
`default_nettype none
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_offset;
  logic [1:0]  status;

  modport source (output valid, payload_offset, status, input ready);
  modport sink   (input valid, payload_offset, status, output ready);
endinterface
`default_nettype wire

### sv/ffa_datapath.sv
`default_nettype none
module ffa_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ffa_pkg::cmd_t      cmd,
  input  wire logic [1:0]         operation,
  input  wire logic [15:0]        req_size,
  input  wire logic [3:0]         align_log2,
  input  wire logic [15:0]        address,
  output ffa_pkg::dp_stat_t       stat,
  output logic [15:0]             payload_offset,
  output logic [1:0]              status
);

  localparam int IW = ffa_pkg::IDX_W;
  localparam int CW = ffa_pkg::CNT_W;
  localparam int M  = ffa_pkg::MAX_SEGMENTS;

  // Segment table memory with registered read; each entry carries its used mark.
  ffa_pkg::seg_rec_t mem [M];
  ffa_pkg::seg_rec_t rd;
  ffa_pkg::seg_rec_t wdata;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     waddr;
  logic              we;

  // Control state and working registers.
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     j;
  ffa_pkg::seg_rec_t cur;
  logic [1:0]        op;
  logic [15:0]       size;
  logic [3:0]        lg;
  logic [15:0]       addr;
  logic [17:0]       aligned;
  logic [18:0]       need;
  logic [15:0]       newhdr;
  logic [16:0]       rem;
  logic [15:0]       res_off;
  logic [1:0]        res_st;

  logic [IW-1:0]     idx_i;
  logic [IW-1:0]     idx1_i;
  logic [CW:0]       idx1;
  logic [16:0]       start_c;
  logic [17:0]       mask_c;
  logic [17:0]       aligned_c;
  logic [18:0]       need_c;
  logic [18:0]       body_x;

  assign idx_i  = idx[IW-1:0];
  assign idx1   = {1'b0, idx} + (CW+1)'(1);
  assign idx1_i = idx1[IW-1:0];
  assign body_x = {2'b00, cur.body};

  // Alignment of the payload that follows the current segment header.
  assign start_c   = {1'b0, rd.hdr} + 17'(ffa_pkg::HEADER_BYTES);
  assign mask_c    = (18'd1 << lg) - 18'd1;
  assign aligned_c = ({1'b0, start_c} + mask_c) & ~mask_c;
  assign need_c    = 19'(size) + {1'b0, aligned_c} - 19'(start_c);

  // Status toward the controller.
  always_comb begin
    stat.op        = ffa_pkg::op_t'(op);
    stat.addr_zero = (addr == 16'd0);
    stat.idx_end   = (idx >= cnt);
    stat.fit       = !cur.used && (aligned[17:16] == 2'b00) && (body_x >= need);
    stat.split     = (body_x > need + 19'(ffa_pkg::HEADER_BYTES + ffa_pkg::SPLIT_SLACK))
                     && (cnt < ffa_pkg::CNT_MAX);
    stat.match     = rd.used && (rd.pay == addr);
    stat.last      = (idx1 >= {1'b0, cnt});
    stat.pair_free = !cur.used && !rd.used;
    stat.up_done   = ({1'b0, j} == idx1);
    stat.dn_done   = ({1'b0, j} + (CW+1)'(1) >= {1'b0, cnt});
  end

  // Memory port selection for each command.
  always_comb begin
    raddr = idx_i;
    we    = 1'b0;
    waddr = idx_i;
    wdata = cur;
    case (cmd)
      ffa_pkg::CMD_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{hdr: 16'd0, body: ffa_pkg::BODY_INIT, pay: 16'd0, used: 1'b0};
      end
      ffa_pkg::CMD_TAKE: begin
        we    = 1'b1;
        wdata = '{hdr: cur.hdr, body: cur.body, pay: aligned[15:0], used: 1'b1};
      end
      ffa_pkg::CMD_TAKE_SPLIT: begin
        we    = 1'b1;
        wdata = '{hdr: cur.hdr, body: need[16:0], pay: aligned[15:0], used: 1'b1};
      end
      ffa_pkg::CMD_SH_UP_RD: raddr = IW'(j - CW'(1));
      ffa_pkg::CMD_SH_UP_WR: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = rd;
      end
      ffa_pkg::CMD_INS_WR: begin
        we    = 1'b1;
        waddr = idx1_i;
        wdata = '{hdr: newhdr, body: rem, pay: 16'd0, used: 1'b0};
      end
      ffa_pkg::CMD_FREE_HIT: begin
        we    = 1'b1;
        wdata = '{hdr: rd.hdr, body: rd.body, pay: rd.pay, used: 1'b0};
      end
      ffa_pkg::CMD_CAP: raddr = idx1_i;
      ffa_pkg::CMD_MERGE_WR: begin
        we    = 1'b1;
        wdata = '{hdr: cur.hdr,
                  body: cur.body + 17'(ffa_pkg::HEADER_BYTES) + rd.body,
                  pay: cur.pay,
                  used: 1'b0};
      end
      ffa_pkg::CMD_SH_DN_RD: raddr = IW'(j + CW'(1));
      ffa_pkg::CMD_SH_DN_WR: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= CW'(1);
      idx  <= '0;
      j    <= '0;
    end else begin
      case (cmd)
        ffa_pkg::CMD_INIT:       cnt <= CW'(1);
        ffa_pkg::CMD_START:      idx <= '0;
        ffa_pkg::CMD_NEXT:       idx <= CW'(idx1);
        ffa_pkg::CMD_TAKE_SPLIT: j <= cnt;
        ffa_pkg::CMD_SH_UP_WR:   j <= j - CW'(1);
        ffa_pkg::CMD_INS_WR:     cnt <= cnt + CW'(1);
        ffa_pkg::CMD_FREE_HIT:   idx <= '0;
        ffa_pkg::CMD_MERGE_WR:   j <= CW'(idx1);
        ffa_pkg::CMD_SH_DN_WR:   j <= j + CW'(1);
        ffa_pkg::CMD_DEC:        cnt <= cnt - CW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd)
      ffa_pkg::CMD_INIT: begin
        res_off <= 16'd0;
        res_st  <= ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_START: begin
        op   <= operation;
        size <= req_size;
        lg   <= align_log2;
        addr <= address;
      end
      ffa_pkg::CMD_ALIGN: begin
        cur     <= rd;
        aligned <= aligned_c;
        need    <= need_c;
      end
      ffa_pkg::CMD_TAKE: begin
        res_off <= aligned[15:0];
        res_st  <= ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_TAKE_SPLIT: begin
        res_off <= aligned[15:0];
        res_st  <= ffa_pkg::ST_OK;
        newhdr  <= aligned[15:0] + size;
        rem     <= 17'(body_x - need - 19'(ffa_pkg::HEADER_BYTES));
      end
      ffa_pkg::CMD_CAP: cur <= rd;
      ffa_pkg::CMD_OK: begin
        res_off <= 16'd0;
        res_st  <= ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_OOM: begin
        res_off <= 16'd0;
        res_st  <= ffa_pkg::ST_OOM;
      end
      ffa_pkg::CMD_UNKNOWN: begin
        res_off <= 16'd0;
        res_st  <= ffa_pkg::ST_UNKNOWN;
      end
      ffa_pkg::CMD_PUBLISH: begin
        payload_offset <= res_off;
        status         <= res_st;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ffa_pkg::dp_stat_t stat,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ffa_pkg::cmd_t          cmd
);

  ffa_pkg::state_t state;
  ffa_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffa_pkg::S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = ffa_pkg::CMD_NONE;
    in_ready       = (state == ffa_pkg::S_IDLE);
    out_valid_next = out_valid && !out_ready;
    case (state)
      ffa_pkg::S_INIT: begin
        cmd        = ffa_pkg::CMD_INIT;
        state_next = ffa_pkg::S_IDLE;
      end
      ffa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd        = ffa_pkg::CMD_START;
          state_next = ffa_pkg::S_DECODE;
        end
      end
      ffa_pkg::S_DECODE: begin
        case (stat.op)
          ffa_pkg::OP_ALLOC: state_next = ffa_pkg::S_A_RD;
          ffa_pkg::OP_FREE: begin
            if (stat.addr_zero) begin
              cmd        = ffa_pkg::CMD_OK;
              state_next = ffa_pkg::S_DONE;
            end else begin
              state_next = ffa_pkg::S_F_RD;
            end
          end
          ffa_pkg::OP_RESET: begin
            cmd        = ffa_pkg::CMD_INIT;
            state_next = ffa_pkg::S_DONE;
          end
          default: begin
            cmd        = ffa_pkg::CMD_OK;
            state_next = ffa_pkg::S_DONE;
          end
        endcase
      end
      ffa_pkg::S_A_RD: begin
        if (stat.idx_end) begin
          cmd        = ffa_pkg::CMD_OOM;
          state_next = ffa_pkg::S_DONE;
        end else begin
          cmd        = ffa_pkg::CMD_RD_IDX;
          state_next = ffa_pkg::S_A_ALIGN;
        end
      end
      ffa_pkg::S_A_ALIGN: begin
        cmd        = ffa_pkg::CMD_ALIGN;
        state_next = ffa_pkg::S_A_FIT;
      end
      ffa_pkg::S_A_FIT: begin
        if (!stat.fit) begin
          cmd        = ffa_pkg::CMD_NEXT;
          state_next = ffa_pkg::S_A_RD;
        end else if (stat.split) begin
          cmd        = ffa_pkg::CMD_TAKE_SPLIT;
          state_next = ffa_pkg::S_UP_CHK;
        end else begin
          cmd        = ffa_pkg::CMD_TAKE;
          state_next = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_UP_CHK: begin
        if (stat.up_done) begin
          cmd        = ffa_pkg::CMD_INS_WR;
          state_next = ffa_pkg::S_DONE;
        end else begin
          cmd        = ffa_pkg::CMD_SH_UP_RD;
          state_next = ffa_pkg::S_UP_WR;
        end
      end
      ffa_pkg::S_UP_WR: begin
        cmd        = ffa_pkg::CMD_SH_UP_WR;
        state_next = ffa_pkg::S_UP_CHK;
      end
      ffa_pkg::S_F_RD: begin
        if (stat.idx_end) begin
          cmd        = ffa_pkg::CMD_UNKNOWN;
          state_next = ffa_pkg::S_DONE;
        end else begin
          cmd        = ffa_pkg::CMD_RD_IDX;
          state_next = ffa_pkg::S_F_CMP;
        end
      end
      ffa_pkg::S_F_CMP: begin
        if (stat.match) begin
          cmd        = ffa_pkg::CMD_FREE_HIT;
          state_next = ffa_pkg::S_M_CHK;
        end else begin
          cmd        = ffa_pkg::CMD_NEXT;
          state_next = ffa_pkg::S_F_RD;
        end
      end
      // Read the current entry, then its neighbor, before deciding on a merge.
      ffa_pkg::S_M_CHK: begin
        if (stat.last) begin
          cmd        = ffa_pkg::CMD_OK;
          state_next = ffa_pkg::S_DONE;
        end else begin
          cmd        = ffa_pkg::CMD_RD_IDX;
          state_next = ffa_pkg::S_M_CAP;
        end
      end
      ffa_pkg::S_M_CAP: begin
        cmd        = ffa_pkg::CMD_CAP;
        state_next = ffa_pkg::S_M_WR;
      end
      ffa_pkg::S_M_WR: begin
        if (stat.pair_free) begin
          cmd        = ffa_pkg::CMD_MERGE_WR;
          state_next = ffa_pkg::S_DN_CHK;
        end else begin
          cmd        = ffa_pkg::CMD_NEXT;
          state_next = ffa_pkg::S_M_CHK;
        end
      end
      ffa_pkg::S_DN_CHK: begin
        if (stat.dn_done) begin
          cmd        = ffa_pkg::CMD_DEC;
          state_next = ffa_pkg::S_M_CHK;
        end else begin
          cmd        = ffa_pkg::CMD_SH_DN_RD;
          state_next = ffa_pkg::S_DN_WR;
        end
      end
      ffa_pkg::S_DN_WR: begin
        cmd        = ffa_pkg::CMD_SH_DN_WR;
        state_next = ffa_pkg::S_DN_CHK;
      end
      ffa_pkg::S_DONE: begin
        // Hand the word to the output register once it is free.
        if (!out_valid || out_ready) begin
          cmd            = ffa_pkg::CMD_PUBLISH;
          out_valid_next = 1'b1;
          state_next     = ffa_pkg::S_IDLE;
        end
      end
      default: state_next = ffa_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/first_fit_arena_allocator_unit.sv
// Channel | Dir | Word fields
// req     | in  | operation[1:0], req_size[15:0], align_log2[3:0], address[15:0]
// rsp     | out | payload_offset[15:0], status[1:0]
//
// One word at a time; the segment table has separate read and write ports,
// with registered read, and every entry carries its own used mark.
// Allocate reads, aligns and tests each scanned segment; a split moves entries up.
// Free compares each scanned segment, then a merge pass checks each adjacent pair
// from the table start, moving entries down after a merge; at most two merges occur.
// After reset, S_INIT builds the single free segment before the first word is taken.
// A new request word is taken while the previous result waits in the output register.
`default_nettype none
module first_fit_arena_allocator_unit (
  input wire logic   clk,
  input wire logic   rst,
  ffa_req_if.sink    req,
  ffa_rsp_if.source  rsp
);

  ffa_pkg::cmd_t     cmd;
  ffa_pkg::dp_stat_t stat;

  // Sequencing of table walks, shifts and merges.
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Segment table and arithmetic.
  ffa_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .operation      (req.operation),
    .req_size       (req.req_size),
    .align_log2     (req.align_log2),
    .address        (req.address),
    .stat           (stat),
    .payload_offset (rsp.payload_offset),
    .status         (rsp.status)
  );

endmodule
`default_nettype wire

### sv/ffa_checker.sv
`default_nettype none
`include "first_fit_arena_allocator_unit_defines.svh"
module ffa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] payload_offset,
  input wire logic [1:0]  status
);

  // A result word waits until taken.
  `FFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // Only defined status codes leave the block.
  `FFA_ASSERT_NOW(a_status_code, out_valid, status <= ffa_pkg::ST_UNKNOWN)
  // Failed operations return a zero offset.
  `FFA_ASSERT_NOW(a_fail_zero, out_valid && status != ffa_pkg::ST_OK, payload_offset == 16'd0)
  // One word at a time: taking a word closes the input.
  `FFA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind first_fit_arena_allocator_unit ffa_checker u_ffa_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .out_valid      (rsp.valid),
  .out_ready      (rsp.ready),
  .payload_offset (rsp.payload_offset),
  .status         (rsp.status)
);
`default_nettype wire
